@@ rtl/core/pfx_pkg.sv @@
// Shared types and constants for the postfix expression evaluator.
// Character codes, status codes and the arithmetic unit request/response types.
// No dependencies.
`default_nettype none

package pfx_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_CARET = 8'h5E;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_DIV_ZERO  = 3'd2,
		ST_MOD_ZERO  = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_SUB = 3'd1,
		ALU_MUL = 3'd2,
		ALU_DIV = 3'd3,
		ALU_MOD = 3'd4,
		ALU_POW = 3'd5
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} alu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/pfx_alu.sv @@
// Iterative 32-bit arithmetic unit: add, sub, mul, restoring divide/modulo,
// and power by squaring on one shared multiplier.
// Depends on pfx_pkg.
`default_nettype none

module pfx_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfx_pkg::alu_req_t req,
	input  wire logic [31:0]       lhs,
	input  wire logic [31:0]       rhs,
	output pfx_pkg::alu_rsp_t      rsp
);
	import pfx_pkg::*;

	typedef enum logic [4:0] {
		A_IDLE    = 5'b00001,
		A_DIV     = 5'b00010,
		A_FIX     = 5'b00100,
		A_POW_ACC = 5'b01000,
		A_POW_SQR = 5'b10000
	} alu_state_t;

	alu_state_t  state_q;
	alu_op_t     op_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [31:0] acc_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic        qneg_q;
	logic        rneg_q;
	logic [31:0] res_q;
	logic        done_q;

	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [31:0] mul_p;
	logic [31:0] lhs_mag;
	logic [31:0] rhs_mag;
	logic [32:0] shl;
	logic [32:0] diff;
	logic        ge;

	always_comb begin
		unique case (state_q)
			A_POW_ACC: begin
				mul_x = acc_q;
				mul_y = x_q;
			end
			A_POW_SQR: begin
				mul_x = x_q;
				mul_y = x_q;
			end
			default: begin
				mul_x = lhs;
				mul_y = rhs;
			end
		endcase
	end

	assign mul_p   = mul_x * mul_y;
	assign lhs_mag = lhs[31] ? (~lhs + 32'd1) : lhs;
	assign rhs_mag = rhs[31] ? (~rhs + 32'd1) : rhs;
	assign shl     = {rem_q, x_q[31]};
	assign diff    = shl - {1'b0, y_q};
	assign ge      = ~diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			op_q    <= ALU_ADD;
			x_q     <= '0;
			y_q     <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			qneg_q  <= 1'b0;
			rneg_q  <= 1'b0;
			res_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						unique case (req.op)
							ALU_ADD: begin
								res_q  <= lhs + rhs;
								done_q <= 1'b1;
							end
							ALU_SUB: begin
								res_q  <= lhs - rhs;
								done_q <= 1'b1;
							end
							ALU_MUL: begin
								res_q  <= mul_p;
								done_q <= 1'b1;
							end
							ALU_DIV, ALU_MOD: begin
								x_q     <= lhs_mag;
								y_q     <= rhs_mag;
								acc_q   <= '0;
								rem_q   <= '0;
								cnt_q   <= '0;
								qneg_q  <= lhs[31] ^ rhs[31];
								rneg_q  <= lhs[31];
								state_q <= A_DIV;
							end
							ALU_POW: begin
								if (rhs[31] || rhs == 32'd0) begin
									res_q  <= 32'd1;
									done_q <= 1'b1;
								end else begin
									x_q     <= lhs;
									y_q     <= rhs;
									acc_q   <= 32'd1;
									state_q <= A_POW_ACC;
								end
							end
							default: begin
								res_q  <= '0;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				A_DIV: begin
					rem_q <= ge ? diff[31:0] : shl[31:0];
					x_q   <= {x_q[30:0], 1'b0};
					acc_q <= {acc_q[30:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					if (op_q == ALU_DIV) begin
						res_q <= qneg_q ? (~acc_q + 32'd1) : acc_q;
					end else begin
						res_q <= rneg_q ? (~rem_q + 32'd1) : rem_q;
					end
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				A_POW_ACC: begin
					if (y_q[0]) begin
						acc_q <= mul_p;
					end
					state_q <= A_POW_SQR;
				end
				A_POW_SQR: begin
					x_q <= mul_p;
					y_q <= {1'b0, y_q[31:1]};
					if (y_q[31:1] == 31'd0) begin
						res_q   <= acc_q;
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end else begin
						state_q <= A_POW_ACC;
					end
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

`default_nettype wire

@@ rtl/core/postfix_expression_evaluator_core.sv @@
// Top level of the postfix expression evaluator: symbol decode, operand stack
// memory, sequencer and result register.
// Depends on pfx_pkg and pfx_alu.
//
// channel  dir  tdata fields (low bit up)          tlast
// s_axis   in   symbol[7:0]                        end_of_expression
// m_axis   out  value[31:0], status[34:32], pad    -
//
// Digits and ignored symbols go from decode to finish; + - * read both operands and
// run once in the shared unit; / and % take one quotient bit per cycle in that unit;
// ^ runs an accumulate and a square step of the shared multiplier per exponent bit.
// The final symbol also passes the emit state and waits while the result register is full.
// Reset clears the stack count, the error and the output valid; no memory clear.
`default_nettype none

module postfix_expression_evaluator_core #(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // symbol[7:0]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata    // value[31:0], status[34:32], zero[39:35]
);
	import pfx_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_RD_RHS = 7'b0000100,
		S_RD_LHS = 7'b0001000,
		S_EXEC   = 7'b0010000,
		S_FINISH = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [7:0]  sym_q;
	logic        last_q;
	logic [CW-1:0] count_q;
	status_t     err_q;
	alu_op_t     op_q;
	logic [31:0] rhs_q;
	logic [31:0] rd_data_q;
	logic        m_valid_q;
	logic [31:0] m_value_q;
	status_t     m_status_q;

	logic [31:0] mem [STACK_DEPTH];

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          is_digit;
	logic          is_op;
	alu_op_t       dec_op;
	logic          rhs_zero;
	logic          zero_fault;
	alu_req_t      alu_req;
	alu_rsp_t      alu_rsp;

	assign cnt_m1     = count_q - CW'(1);
	assign cnt_m2     = count_q - CW'(2);
	assign is_digit   = (sym_q >= CH_ZERO) && (sym_q <= CH_NINE);
	assign rhs_zero   = (rhs_q == 32'd0);
	assign zero_fault = rhs_zero && ((op_q == ALU_DIV) || (op_q == ALU_MOD));

	always_comb begin
		is_op  = 1'b1;
		dec_op = ALU_ADD;
		unique case (sym_q)
			CH_PLUS:  dec_op = ALU_ADD;
			CH_MINUS: dec_op = ALU_SUB;
			CH_STAR:  dec_op = ALU_MUL;
			CH_SLASH: dec_op = ALU_DIV;
			CH_PCT:   dec_op = ALU_MOD;
			CH_CARET: dec_op = ALU_POW;
			default:  is_op  = 1'b0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_DECODE: rd_addr = cnt_m1[AW-1:0];
			S_RD_RHS: rd_addr = cnt_m2[AW-1:0];
			default:  rd_addr = '0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = {28'd0, sym_q[3:0]};
		if (state_q == S_DECODE && err_q == ST_OK && is_digit
				&& count_q < CW'(STACK_DEPTH)) begin
			mem_we = 1'b1;
		end else if (state_q == S_EXEC && alu_rsp.done) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_m2[AW-1:0];
			mem_wdata = alu_rsp.result;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign alu_req.start = (state_q == S_RD_LHS) && !zero_fault;
	assign alu_req.op    = op_q;

	pfx_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.lhs    (rd_data_q),
		.rhs    (rhs_q),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sym_q      <= '0;
			last_q     <= 1'b0;
			count_q    <= '0;
			err_q      <= ST_OK;
			op_q       <= ALU_ADD;
			rhs_q      <= '0;
			m_valid_q  <= 1'b0;
			m_value_q  <= '0;
			m_status_q <= ST_OK;
		end else begin
			if (m_axis_tready && state_q != S_EMIT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						sym_q   <= s_axis_tdata;
						last_q  <= s_axis_tlast;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FINISH;
					if (err_q == ST_OK) begin
						if (is_digit) begin
							if (count_q >= CW'(STACK_DEPTH)) begin
								err_q <= ST_OVERFLOW;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end else if (is_op) begin
							if (count_q < CW'(2)) begin
								err_q <= ST_MALFORMED;
							end else begin
								op_q    <= dec_op;
								state_q <= S_RD_RHS;
							end
						end
					end
				end
				S_RD_RHS: begin
					rhs_q   <= rd_data_q;
					state_q <= S_RD_LHS;
				end
				S_RD_LHS: begin
					if (zero_fault) begin
						err_q   <= (op_q == ALU_DIV) ? ST_DIV_ZERO : ST_MOD_ZERO;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (alu_rsp.done) begin
						count_q <= cnt_m1;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						if (err_q != ST_OK) begin
							m_value_q  <= '0;
							m_status_q <= err_q;
						end else if (count_q == CW'(1)) begin
							m_value_q  <= rd_data_q;
							m_status_q <= ST_OK;
						end else begin
							m_value_q  <= '0;
							m_status_q <= ST_MALFORMED;
						end
						count_q <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, m_status_q, m_value_q};

endmodule

`default_nettype wire

@@ rtl/core/pfx_checker.sv @@
// Port-level checks for the postfix expression evaluator, bound to the top level.
// Depends on pfx_pkg and postfix_expression_evaluator_core.
`default_nettype none

module pfx_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata
);
	import pfx_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
			&& $stable(s_axis_tlast))
		else $error("input transaction changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[34:32] != ST_OK |-> m_axis_tdata[31:0] == 32'd0)
		else $error("nonzero value with error status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0
			&& (m_axis_tdata[34:32] == ST_OK || m_axis_tdata[34:32] == ST_MALFORMED
			|| m_axis_tdata[34:32] == ST_DIV_ZERO || m_axis_tdata[34:32] == ST_MOD_ZERO
			|| m_axis_tdata[34:32] == ST_OVERFLOW))
		else $error("bad status code or padding");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while previous symbol in work");

endmodule

bind postfix_expression_evaluator_core pfx_checker u_pfx_checker (.*);

`default_nettype wire
